// ===== rtl/ptcp_pkg.sv =====
// Shared types, constants and tables for the pan-tilt camera pose block.
package ptcp_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int WORK_BITS      = 30;

    localparam int ANG_W   = 16;                     // input angle width
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;     // Q1.F plus sign
    localparam int XY_W    = WORK_BITS + 2;          // Q2.30
    localparam int Z_W     = 25;                     // 2^-16 degree units
    localparam int IDX_W   = 5;                      // atan table index
    localparam int RSH     = WORK_BITS - TRIG_FRAC_BITS;
    localparam int HINGE_W = 21;
    localparam int LEN_W   = 20;
    localparam int POS_W   = 22;
    localparam int CFG_W   = 21;
    localparam int CFG_IDX_W = 2;

    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int FULL_TURN    = 46080;
    localparam int Z_SHIFT      = 9;                 // 1/128 deg to 2^-16 deg

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic signed [HINGE_W-1:0] HINGE_FWD_RST = HINGE_W'(225000);
    localparam logic signed [HINGE_W-1:0] HINGE_HGT_RST = HINGE_W'(320000);
    localparam logic [LEN_W-1:0]          PANEL_LEN_RST = LEN_W'(520000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HINGE_FWD = 2'd0,
        CFG_HINGE_HGT = 2'd1,
        CFG_PANEL_LEN = 2'd2
    } t_cfg_idx;

    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [Z_W-1:0]    t_z;
    typedef logic signed [TRIG_W-1:0] t_trig;

    // One rotation in flight through the cell chain.
    typedef struct packed {
        t_xy  x;
        t_xy  y;
        t_z   z;
        logic flip;     // cosine to be negated after folding
    } t_cordic;

    // atan(2^-i) in degrees times 65536, rounded.
    function automatic t_z atan_q16(input logic [IDX_W-1:0] i);
        t_z a;
        case (i)
            5'd0:    a = Z_W'(2949120);
            5'd1:    a = Z_W'(1740967);
            5'd2:    a = Z_W'(919879);
            5'd3:    a = Z_W'(466945);
            5'd4:    a = Z_W'(234379);
            5'd5:    a = Z_W'(117304);
            5'd6:    a = Z_W'(58666);
            5'd7:    a = Z_W'(29335);
            5'd8:    a = Z_W'(14668);
            5'd9:    a = Z_W'(7334);
            5'd10:   a = Z_W'(3667);
            5'd11:   a = Z_W'(1833);
            5'd12:   a = Z_W'(917);
            5'd13:   a = Z_W'(458);
            5'd14:   a = Z_W'(229);
            5'd15:   a = Z_W'(115);
            5'd16:   a = Z_W'(57);
            5'd17:   a = Z_W'(29);
            5'd18:   a = Z_W'(14);
            5'd19:   a = Z_W'(7);
            5'd20:   a = Z_W'(4);
            5'd21:   a = Z_W'(2);
            5'd22:   a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Round a Q2.30 CORDIC output to Q1.F (add half, floor) and clamp to +-1.0.
    function automatic t_trig trig_round(input t_xy v);
        logic signed [XY_W:0]       sum;
        logic signed [XY_W-RSH:0]   r;
        logic signed [XY_W-RSH:0]   lim;
        t_trig                      q;
        sum = $signed({v[XY_W-1], v}) + $signed((XY_W+1)'(1) <<< (RSH - 1));
        r   = sum[XY_W:RSH];
        lim = (XY_W-RSH+1)'(1) <<< TRIG_FRAC_BITS;
        if (r > lim) begin
            q = TRIG_W'(lim);
        end else if (r < -lim) begin
            q = TRIG_W'(-lim);
        end else begin
            q = TRIG_W'(r);
        end
        return q;
    endfunction

endpackage

// ===== rtl/ptcp_angle_fold.sv =====
// Angle negation, wrap and quadrant fold into the CORDIC start vector.
module ptcp_angle_fold (
    input  logic                             i_clk,
    input  logic signed [ptcp_pkg::ANG_W-1:0] i_angle,
    output ptcp_pkg::t_cordic                o_q
);

    localparam int N_W = ptcp_pkg::ANG_W + 2;

    logic signed [N_W-1:0] neg_n;
    logic signed [N_W-1:0] wrap_a;
    logic signed [N_W-1:0] wrap_b;
    logic signed [N_W-1:0] fold_n;
    logic                  fold;
    ptcp_pkg::t_cordic     n_q;
    ptcp_pkg::t_cordic     r_q;

    always_comb begin
        neg_n = -N_W'(i_angle);
        wrap_a = neg_n;
        if (neg_n > N_W'(ptcp_pkg::HALF_TURN)) begin
            wrap_a = neg_n - N_W'(ptcp_pkg::FULL_TURN);
        end
        wrap_b = wrap_a;
        if (wrap_a <= -N_W'(ptcp_pkg::HALF_TURN)) begin
            wrap_b = wrap_a + N_W'(ptcp_pkg::FULL_TURN);
        end
        fold   = 1'b0;
        fold_n = wrap_b;
        if (wrap_b > N_W'(ptcp_pkg::QUARTER_TURN)) begin
            fold_n = N_W'(ptcp_pkg::HALF_TURN) - wrap_b;
            fold   = 1'b1;
        end else if (wrap_b < -N_W'(ptcp_pkg::QUARTER_TURN)) begin
            fold_n = -N_W'(ptcp_pkg::HALF_TURN) - wrap_b;
            fold   = 1'b1;
        end
        n_q.x    = ptcp_pkg::CORDIC_GAIN;
        n_q.y    = '0;
        n_q.z    = ptcp_pkg::Z_W'(fold_n) <<< ptcp_pkg::Z_SHIFT;
        n_q.flip = fold;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== rtl/ptcp_cell.sv =====
// One CORDIC micro-rotation cell; the stage index is tied off by the caller.
module ptcp_cell (
    input  logic                           i_clk,
    input  logic [ptcp_pkg::IDX_W-1:0]     i_stage,
    input  ptcp_pkg::t_cordic              i_d,
    output ptcp_pkg::t_cordic              o_q
);

    ptcp_pkg::t_xy     xs;
    ptcp_pkg::t_xy     ys;
    ptcp_pkg::t_xy     x_in;
    ptcp_pkg::t_xy     y_in;
    ptcp_pkg::t_z      ang;
    ptcp_pkg::t_cordic n_q;
    ptcp_pkg::t_cordic r_q;

    always_comb begin
        x_in = i_d.x;
        y_in = i_d.y;
        xs   = x_in >>> i_stage;
        ys   = y_in >>> i_stage;
        ang  = ptcp_pkg::atan_q16(i_stage);
        n_q.flip = i_d.flip;
        if (!i_d.z[ptcp_pkg::Z_W-1]) begin
            n_q.x = x_in - ys;
            n_q.y = y_in + xs;
            n_q.z = i_d.z - ang;
        end else begin
            n_q.x = x_in + ys;
            n_q.y = y_in - xs;
            n_q.z = i_d.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== rtl/pan_tilt_camera_pose.sv =====
// Top level: pan-tilt camera pose pipeline (angle fold, CORDIC cell chains, matrix and position).
//
// Pan-tilt camera pose. An item (pan and tilt in 1/128 degree) is taken at
// every rising edge where start is high and busy is low; busy is held low, so
// a new item may enter in every cycle. Each item gives exactly one result,
// shown on the o_ ports for a single cycle with o_valid high, in input order.
// The receiver cannot stall the block and must take every result as it comes.
// The registers along the path are, in order: angle fold, one per CORDIC cell,
// rounding, the products and the output register. Throughput is one item per
// cycle, set by the two chains of CORDIC cells (pan and tilt), each cell a
// registered micro-rotation. Configuration (hinge offsets, panel length) is
// written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only
// while no item is in flight, as the block does not enforce it. Unknown indexes
// are dropped. The rotation is P(tilt)*Y(pan) in Q1.14, positions in micrometres.
module pan_tilt_camera_pose (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ptcp_pkg::ANG_W-1:0]    i_pan_angle,
    input  logic signed [ptcp_pkg::ANG_W-1:0]    i_tilt_angle,
    input  logic                                 i_cfg_we,
    input  logic [ptcp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ptcp_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                 o_valid,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r00,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r01,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r02,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r10,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r11,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r20,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r21,
    output logic signed [ptcp_pkg::TRIG_W-1:0]   o_r22,
    output logic signed [ptcp_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [ptcp_pkg::POS_W-1:0]    o_pos_z
);

    localparam int STAGES = ptcp_pkg::CORDIC_STAGES;
    localparam int LAT    = STAGES + 4;
    localparam int F      = ptcp_pkg::TRIG_FRAC_BITS;
    localparam int TW     = ptcp_pkg::TRIG_W;
    localparam int PW     = 2 * TW;                          // trig product
    localparam int LPW    = ptcp_pkg::LEN_W + 1 + TW;        // length product
    localparam int PSW    = ptcp_pkg::POS_W;

    // ---------------- configuration registers ----------------
    logic signed [ptcp_pkg::HINGE_W-1:0] r_hinge_fwd;
    logic signed [ptcp_pkg::HINGE_W-1:0] r_hinge_hgt;
    logic [ptcp_pkg::LEN_W-1:0]          r_panel_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hinge_fwd <= ptcp_pkg::HINGE_FWD_RST;
            r_hinge_hgt <= ptcp_pkg::HINGE_HGT_RST;
            r_panel_len <= ptcp_pkg::PANEL_LEN_RST;
        end else if (i_cfg_we) begin
            case (ptcp_pkg::t_cfg_idx'(i_cfg_idx))
                ptcp_pkg::CFG_HINGE_FWD: r_hinge_fwd <= i_cfg_data[ptcp_pkg::HINGE_W-1:0];
                ptcp_pkg::CFG_HINGE_HGT: r_hinge_hgt <= i_cfg_data[ptcp_pkg::HINGE_W-1:0];
                ptcp_pkg::CFG_PANEL_LEN: r_panel_len <= i_cfg_data[ptcp_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- item tracking ----------------
    // Never stalls: the pipeline moves every cycle.
    assign busy = 1'b0;

    logic           accept;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign accept = start & ~busy;
    assign n_vld  = {r_vld[LAT-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[LAT-1];

    // ---------------- angle fold and CORDIC chains ----------------
    ptcp_pkg::t_cordic pan_chain  [0:STAGES];
    ptcp_pkg::t_cordic tilt_chain [0:STAGES];

    ptcp_angle_fold u_fold_pan (
        .i_clk   (i_clk),
        .i_angle (i_pan_angle),
        .o_q     (pan_chain[0])
    );

    ptcp_angle_fold u_fold_tilt (
        .i_clk   (i_clk),
        .i_angle (i_tilt_angle),
        .o_q     (tilt_chain[0])
    );

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        ptcp_cell u_pan (
            .i_clk   (i_clk),
            .i_stage (ptcp_pkg::IDX_W'(g)),
            .i_d     (pan_chain[g]),
            .o_q     (pan_chain[g+1])
        );
        ptcp_cell u_tilt (
            .i_clk   (i_clk),
            .i_stage (ptcp_pkg::IDX_W'(g)),
            .i_d     (tilt_chain[g]),
            .o_q     (tilt_chain[g+1])
        );
    end

    // ---------------- rounding to Q1.14, cosine sign after fold ----------------
    ptcp_pkg::t_trig r_sp, r_cp, r_st, r_ct;
    ptcp_pkg::t_trig n_cp, n_ct;

    always_comb begin
        n_cp = ptcp_pkg::trig_round(pan_chain[STAGES].x);
        n_ct = ptcp_pkg::trig_round(tilt_chain[STAGES].x);
        if (pan_chain[STAGES].flip) begin
            n_cp = -n_cp;
        end
        if (tilt_chain[STAGES].flip) begin
            n_ct = -n_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp <= ptcp_pkg::trig_round(pan_chain[STAGES].y);
        r_cp <= n_cp;
        r_st <= ptcp_pkg::trig_round(tilt_chain[STAGES].y);
        r_ct <= n_ct;
    end

    // ---------------- products, rounded back to Q1.14 / whole um ----------------
    logic signed [PW-1:0]  p_ctcp, p_ctsp, p_stcp, p_stsp;
    logic signed [LPW-1:0] p_lst, p_lct;
    logic signed [LPW-1:0] len_s;
    ptcp_pkg::t_trig       r_m_ctcp, r_m_ctsp, r_m_stcp, r_m_stsp;
    ptcp_pkg::t_trig       r_st2, r_ct2, r_sp2, r_cp2;
    logic signed [PSW-1:0] r_m_lst, r_m_lct;

    assign len_s  = LPW'($signed({1'b0, r_panel_len}));
    assign p_ctcp = PW'(r_ct) * PW'(r_cp) + (PW'(1) <<< (F - 1));
    assign p_ctsp = PW'(r_ct) * PW'(r_sp) + (PW'(1) <<< (F - 1));
    assign p_stcp = PW'(r_st) * PW'(r_cp) + (PW'(1) <<< (F - 1));
    assign p_stsp = PW'(r_st) * PW'(r_sp) + (PW'(1) <<< (F - 1));
    assign p_lst  = len_s * LPW'(r_st) + (LPW'(1) <<< (F - 1));
    assign p_lct  = len_s * LPW'(r_ct) + (LPW'(1) <<< (F - 1));

    always_ff @(posedge i_clk) begin
        r_m_ctcp <= TW'(p_ctcp >>> F);
        r_m_ctsp <= TW'(p_ctsp >>> F);
        r_m_stcp <= TW'(p_stcp >>> F);
        r_m_stsp <= TW'(p_stsp >>> F);
        r_m_lst  <= PSW'(p_lst >>> F);
        r_m_lct  <= PSW'(p_lct >>> F);
        r_st2    <= r_st;
        r_ct2    <= r_ct;
        r_sp2    <= r_sp;
        r_cp2    <= r_cp;
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        o_r00   <= r_m_ctcp;
        o_r01   <= -r_m_ctsp;
        o_r02   <= r_st2;
        o_r10   <= r_sp2;
        o_r11   <= r_cp2;
        o_r20   <= -r_m_stcp;
        o_r21   <= r_m_stsp;
        o_r22   <= r_ct2;
        o_pos_x <= PSW'(r_hinge_fwd) + r_m_lst;
        o_pos_z <= PSW'(r_hinge_hgt) + r_m_lct;
    end

endmodule
